/* sv/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants and controller/datapath handshake types for the program
// counter sample profile table.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int CFG_IDX_W  = 1;
	localparam int ENTRIES_W  = 7;
	localparam int LIMIT_W    = 16;
	localparam int WORD_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT = 1'b1;

	localparam logic [ENTRIES_W-1:0] MAX_ENTRIES_RESET = 7'd50;
	localparam logic [LIMIT_W-1:0]   STUCK_LIMIT_RESET = 16'd255;

	localparam logic [WORD_W-1:0]  CNT_MAX = '1;
	localparam logic [LIMIT_W-1:0] RUN_MAX = '1;

	typedef struct packed {
		logic load;    // latch a new sample and clear the scan results
		logic rd;      // read the next table slot
		logic commit;  // write the chosen slot and publish the result
	} psp_cmd_t;

	typedef struct packed {
		logic last_rd; // the slot being read is the final one
	} psp_status_t;

	function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + WORD_W'(1);
	endfunction

endpackage

/* sv/psp_ctrl.sv */
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer for one sample: walk every slot, let the last read settle, then
// commit the update.
// ----------------------------------------------------------------------------
module psp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output psp_pkg::psp_cmd_t    cmd,
	input  psp_pkg::psp_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.last_rd) state_q <= ST_DRAIN;
				end
				ST_DRAIN:  state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.rd     = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT);
	end

endmodule

/* sv/psp_datapath.sv */
// ----------------------------------------------------------------------------
// psp_datapath
// Slot memory, scan registers for hit, free and oldest slot, run tracking,
// sample counters and the result register.
// ----------------------------------------------------------------------------
module psp_datapath #(
	parameter int TABLE_DEPTH = psp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  psp_pkg::psp_cmd_t                    cmd,
	output psp_pkg::psp_status_t                 status,
	input  logic                                 cfg_valid,
	input  logic [psp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [psp_pkg::WORD_W-1:0]           cfg_data,
	input  logic [psp_pkg::WORD_W-1:0]           sample_pc,
	input  logic [psp_pkg::WORD_W-1:0]           function_key,
	input  logic [psp_pkg::WORD_W-1:0]           sample_time,
	input  logic                                 thread_yielded,
	output logic                                 done,
	output logic [psp_pkg::WORD_W-1:0]           entry_hits,
	output logic                                 was_new,
	output logic                                 did_evict,
	output logic [psp_pkg::WORD_W-1:0]           evicted_key,
	output logic                                 stuck,
	output logic [psp_pkg::WORD_W-1:0]           total_count,
	output logic [psp_pkg::WORD_W-1:0]           kept_count
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > psp_pkg::ENTRIES_W) ? CNT_W : psp_pkg::ENTRIES_W;
	localparam int W     = psp_pkg::WORD_W;

	typedef struct packed {
		logic [W-1:0] key;
		logic [W-1:0] hits;
		logic [W-1:0] last_time;
	} slot_t;

	slot_t mem [TABLE_DEPTH];
	slot_t rdata_q;

	logic [TABLE_DEPTH-1:0] valid_q;

	logic [psp_pkg::ENTRIES_W-1:0] max_entries_q;
	logic [psp_pkg::LIMIT_W-1:0]   stuck_limit_q;

	// Latched sample
	logic [W-1:0] pc_q, key_q, time_q;
	logic         yield_q;

	logic [IDX_W-1:0] idx_q, idx_s1;
	logic             eval_s1;

	// Scan results
	logic [CNT_W-1:0] used_q;
	logic             hit_found_q, free_found_q, old_found_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [W-1:0]     hit_hits_q, old_time_q, old_key_q, old_hits_q;

	logic [W-1:0]               prev_pc_q, total_q, kept_q;
	logic [psp_pkg::LIMIT_W-1:0] run_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= psp_pkg::MAX_ENTRIES_RESET;
			stuck_limit_q <= psp_pkg::STUCK_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psp_pkg::REG_MAX_ENTRIES: max_entries_q <= cfg_data[psp_pkg::ENTRIES_W-1:0];
				psp_pkg::REG_STUCK_LIMIT: stuck_limit_q <= cfg_data[psp_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign status.last_rd = (idx_q == IDX_W'(TABLE_DEPTH - 1));

	// Commit decisions
	logic             evict_c;
	logic [IDX_W-1:0] slot_c;
	logic [W-1:0]     new_hits_c, kept_sub_c, kept_new_c;
	logic [CMP_W-1:0] max_eff_c;
	logic             run_restart_c;
	logic [psp_pkg::LIMIT_W-1:0] run_base_c, run_new_c;
	logic             stuck_c;

	always_comb begin
		max_eff_c = (max_entries_q == '0) ? CMP_W'(1) : CMP_W'(max_entries_q);
		// A limit above the depth never fires here; a full table evicts anyway.
		evict_c   = !hit_found_q && (!free_found_q || (CMP_W'(used_q) >= max_eff_c));
		if (hit_found_q) begin
			slot_c     = hit_idx_q;
			new_hits_c = psp_pkg::sat_inc(hit_hits_q);
		end else begin
			slot_c     = evict_c ? old_idx_q : free_idx_q;
			new_hits_c = W'(1);
		end
		if (evict_c)
			kept_sub_c = (kept_q >= old_hits_q) ? kept_q - old_hits_q : '0;
		else
			kept_sub_c = kept_q;
		kept_new_c = psp_pkg::sat_inc(kept_sub_c);

		run_restart_c = (pc_q != prev_pc_q) || yield_q;
		run_base_c    = run_restart_c ? '0 : run_q;
		if (run_base_c != psp_pkg::RUN_MAX) begin
			run_new_c = run_base_c + psp_pkg::LIMIT_W'(1);
			stuck_c   = (run_new_c == stuck_limit_q);
		end else begin
			run_new_c = run_base_c;
			stuck_c   = 1'b0;
		end
	end

	// Slot memory: one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd)
			rdata_q <= mem[idx_q];
		if (cmd.commit)
			mem[slot_c] <= '{key: key_q, hits: new_hits_c, last_time: time_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pc_q    <= sample_pc;
			key_q   <= function_key;
			time_q  <= sample_time;
			yield_q <= thread_yielded;
		end
		idx_s1 <= idx_q;
	end

	// Scan evaluation of each slot in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			eval_s1      <= 1'b0;
			used_q       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			old_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
			old_idx_q    <= '0;
			hit_hits_q   <= '0;
			old_time_q   <= '0;
			old_key_q    <= '0;
			old_hits_q   <= '0;
		end else begin
			eval_s1 <= cmd.rd;
			if (cmd.load) begin
				idx_q        <= '0;
				used_q       <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				old_found_q  <= 1'b0;
			end else begin
				if (cmd.rd)
					idx_q <= idx_q + IDX_W'(1);
				if (eval_s1) begin
					if (valid_q[idx_s1]) begin
						used_q <= used_q + CNT_W'(1);
						if (!hit_found_q && rdata_q.key == key_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= idx_s1;
							hit_hits_q  <= rdata_q.hits;
						end
						if (!old_found_q || rdata_q.last_time < old_time_q) begin
							old_found_q <= 1'b1;
							old_idx_q   <= idx_s1;
							old_time_q  <= rdata_q.last_time;
							old_key_q   <= rdata_q.key;
							old_hits_q  <= rdata_q.hits;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
				end
			end
		end
	end

	// Persistent state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			prev_pc_q <= '0;
			run_q     <= '0;
			total_q   <= '0;
			kept_q    <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.commit) begin
				valid_q[slot_c] <= 1'b1;
				if (run_restart_c)
					prev_pc_q <= pc_q;
				run_q   <= run_new_c;
				total_q <= psp_pkg::sat_inc(total_q);
				kept_q  <= kept_new_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			entry_hits  <= new_hits_c;
			was_new     <= !hit_found_q;
			did_evict   <= evict_c;
			evicted_key <= evict_c ? old_key_q : '0;
			stuck       <= stuck_c;
			total_count <= psp_pkg::sat_inc(total_q);
			kept_count  <= kept_new_c;
		end
	end

endmodule

/* sv/pc_sample_profile_table.sv */
// ----------------------------------------------------------------------------
// pc_sample_profile_table
// Bounded least-recently-seen histogram of program counter samples, keyed by
// function, with a same-pc stuck detector.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  sample    start / busy           sample_pc, function_key, sample_time,
//                                   thread_yielded
//  result    done (one cycle)       entry_hits, was_new, did_evict,
//                                   evicted_key, stuck, total_count, kept_count
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample runs from start to the done beat through the scan, drain and
// commit states: the slot memory has a single read port, so the lookup and
// the oldest-entry search read one slot per cycle, then the drain state
// settles the last read and the commit state commits the update. Reset is
// asynchronous; it empties the table at once, with no clearing pass. The
// result beat cannot be held off, and a new sample may start in the cycle the
// done beat is shown. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module pc_sample_profile_table #(
	parameter int TABLE_DEPTH = psp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [psp_pkg::WORD_W-1:0]    sample_pc,
	input  logic [psp_pkg::WORD_W-1:0]    function_key,
	input  logic [psp_pkg::WORD_W-1:0]    sample_time,
	input  logic                          thread_yielded,
	output logic                          done,
	output logic [psp_pkg::WORD_W-1:0]    entry_hits,
	output logic                          was_new,
	output logic                          did_evict,
	output logic [psp_pkg::WORD_W-1:0]    evicted_key,
	output logic                          stuck,
	output logic [psp_pkg::WORD_W-1:0]    total_count,
	output logic [psp_pkg::WORD_W-1:0]    kept_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psp_pkg::WORD_W-1:0]    cfg_data
);

	psp_pkg::psp_cmd_t    cmd;
	psp_pkg::psp_status_t status;

	assign cfg_ready = 1'b1;

	psp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	psp_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_pc      (sample_pc),
		.function_key   (function_key),
		.sample_time    (sample_time),
		.thread_yielded (thread_yielded),
		.done           (done),
		.entry_hits     (entry_hits),
		.was_new        (was_new),
		.did_evict      (did_evict),
		.evicted_key    (evicted_key),
		.stuck          (stuck),
		.total_count    (total_count),
		.kept_count     (kept_count)
	);

endmodule
